[rtl/sjg_pkg.sv]
package sjg_pkg;

    // Glyph geometry
    localparam int GLYPH_ROWS = 8;
    localparam logic [2:0] LAST_ROW = 3'd7;

    // Half-width glyphs start at this byte address, eight bytes each
    localparam logic [11:0] HALF_GLYPH_BASE = 12'h110;
    localparam logic [7:0]  HALF_CODE_BIAS  = 8'h20;

    // Full-width space glyph, used for every unmapped code (address 128)
    localparam logic [12:0] SPACE_GLYPH_INDEX = 13'd16;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    // Font memory select on a load
    localparam logic TABLE_HALF = 1'b0;
    localparam logic TABLE_FULL = 1'b1;

    // Configuration register indexes
    localparam logic [0:0] CFG_ROTATION  = 1'b0;
    localparam logic [0:0] CFG_DIRECTION = 1'b1;

    // Chars-used codes
    localparam logic [1:0] USED_ONE = 2'd1;
    localparam logic [1:0] USED_TWO = 2'd2;

    typedef enum logic [1:0] {
        MODE_HALF_ONE,
        MODE_HALF_PAIR,
        MODE_FULL
    } mode_t;

    typedef struct packed {
        logic        req_type;
        logic        load_table;
        logic [15:0] load_address;
        logic [7:0]  load_data;
        logic [7:0]  lead_byte;
        logic [7:0]  trail_byte;
    } in_item_t;

    // Controller -> datapath
    typedef struct packed {
        logic       take;
        logic       rd_en;
        logic       rd_sel_trail;
        logic [2:0] rd_row;
        logic       emit;
        logic [2:0] row_idx;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;
        logic pair;
    } stat_t;

    function automatic logic is_half_width(input logic [7:0] c);
        return (c >= 8'h20 && c <= 8'h7F) || (c >= 8'hA1 && c <= 8'hDF);
    endfunction

    // Shift-JIS code to full-width glyph number (byte address / 8)
    function automatic logic [12:0] full_glyph_index(input logic [7:0] hi,
                                                     input logic [7:0] lo);
        logic [15:0]        code;
        logic signed [17:0] off;
        logic signed [17:0] k;
        logic signed [17:0] adj;
        logic signed [17:0] base;
        logic signed [17:0] v;
        logic               ok;
        logic [12:0]        idx;
        code = {hi, lo};
        off  = signed'({2'b00, code}) - 18'sh08140;
        k    = signed'({10'd0, hi}) - 18'sd136;
        adj  = '0;
        base = '0;
        v    = '0;
        ok   = 1'b1;
        idx  = SPACE_GLYPH_INDEX;
        if ((hi >= 8'h81 && hi <= 8'h9F) || (hi >= 8'hE0 && hi <= 8'hEF))
        begin
            if (code >= 16'h8140 && code <= 16'h88FC)
            begin
                // symbol, alphanumeric, kana, Greek/Cyrillic, special blocks
                priority if (code <= 16'h817E) adj = 18'sd16;
                else if (code >= 16'h8180 && code <= 16'h81FC) adj = 18'sd15;
                else if (code >= 16'h824F && code <= 16'h8279) adj = -18'sd52;
                else if (code >= 16'h8281 && code <= 16'h82F1) adj = -18'sd53;
                else if (code >= 16'h8340 && code <= 16'h837E) adj = -18'sd120;
                else if (code >= 16'h8380 && code <= 16'h83D6) adj = -18'sd121;
                else if (code >= 16'h8440 && code <= 16'h847E) adj = -18'sd188;
                else if (code >= 16'h8480 && code <= 16'h84BE) adj = -18'sd189;
                else if (code >= 16'h8740 && code <= 16'h877E) adj = -18'sd768;
                else if (code >= 16'h8780 && code <= 16'h879C) adj = -18'sd769;
                else if (code >= 16'h889F) adj = -18'sd837;
                else ok = 1'b0;
                if (ok)
                begin
                    v   = off + adj;
                    idx = v[12:0];
                end
            end
            else if ((code >= 16'h8940 && code <= 16'h9FFC) ||
                     (code >= 16'hE040 && code <= 16'hEAA4))
            begin
                // kanji blocks; trail 0x7F is a hole
                if (lo != 8'h7F)
                begin
                    base = (lo <= 8'h7E) ? 18'sd836 : 18'sd837;
                    v    = off - (base + k) - 18'sd67 * k;
                    if (code >= 16'hE040)
                        v = v - 18'sd12032;
                    idx = v[12:0];
                end
            end
        end
        return idx;
    endfunction

endpackage

[rtl/sjg_cmd_if.sv]
interface sjg_cmd_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        load_table;
    logic [15:0] load_address;
    logic [7:0]  load_data;
    logic [7:0]  lead_byte;
    logic [7:0]  trail_byte;

    modport source (
        output valid, req_type, load_table, load_address, load_data,
               lead_byte, trail_byte,
        input  ready
    );

    modport sink (
        input  valid, req_type, load_table, load_address, load_data,
               lead_byte, trail_byte,
        output ready
    );
endinterface

[rtl/sjg_row_if.sv]
interface sjg_row_if;
    logic       valid;
    logic       ready;
    logic [2:0] row_index;
    logic [7:0] row_bits;
    logic [1:0] chars_used;
    logic       last_row;

    modport source (
        output valid, row_index, row_bits, chars_used, last_row,
        input  ready
    );

    modport sink (
        input  valid, row_index, row_bits, chars_used, last_row,
        output ready
    );
endinterface

[rtl/sjg_ram.sv]
module sjg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sjg_ctrl.sv]
module sjg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_req_type,
    input  sjg_pkg::stat_t stat,
    output logic           in_ready,
    output sjg_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [2:0] row_reg, row_next;
    logic       fetch_last;

    assign in_ready   = (state_reg == ST_IDLE);
    assign fetch_last = stat.pair ? (cnt_reg == 4'd15) : (cnt_reg == 4'd7);

    // Next state and commands
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        row_next         = row_reg;
        cmd              = '0;
        cmd.take         = in_valid && in_ready;
        cmd.rd_sel_trail = cnt_reg[3];
        cmd.rd_row       = cnt_reg[2:0];
        cmd.row_idx      = row_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_req_type == sjg_pkg::REQ_RENDER)
                begin
                    state_next = ST_FETCH;
                    cnt_next   = '0;
                end
            end
            ST_FETCH:
            begin
                cmd.rd_en = 1'b1;
                if (fetch_last)
                    state_next = ST_WAIT;
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            ST_WAIT:
            begin
                // last byte lands in the buffer this cycle
                state_next = ST_EMIT;
                row_next   = '0;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (row_reg == sjg_pkg::LAST_ROW)
                        state_next = ST_IDLE;
                    else
                        row_next = row_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
        end
    end

endmodule

[rtl/sjg_dp.sv]
module sjg_dp #(
    parameter int HALF_FONT_BYTES = 2048,
    parameter int FULL_FONT_BYTES = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sjg_pkg::cmd_t     cmd,
    input  sjg_pkg::in_item_t item,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [1:0]        cfg_data,
    input  logic              out_ready,
    output sjg_pkg::stat_t    stat,
    output logic              out_valid,
    output logic [2:0]        row_index,
    output logic [7:0]        row_bits,
    output logic [1:0]        chars_used,
    output logic              last_row
);

    localparam int HAW = $clog2(HALF_FONT_BYTES);
    localparam int FAW = $clog2(FULL_FONT_BYTES);

    // Config and per-item state
    logic [1:0]     rotation_reg;
    logic [1:0]     direction_reg;
    sjg_pkg::mode_t mode_reg;
    logic           swap_reg;
    logic [7:0]     lead_off_reg;
    logic [7:0]     trail_off_reg;
    logic [12:0]    glyph_idx_reg;

    // Read capture and row buffers
    logic           cap_valid_reg;
    logic           cap_trail_reg;
    logic [7:0]     buf_a_reg [8];
    logic [7:0]     buf_b_reg [8];

    // Output register
    logic           out_valid_reg;
    logic [2:0]     row_index_reg;
    logic [7:0]     row_bits_reg;
    logic [1:0]     chars_used_reg;
    logic           last_row_reg;

    logic           load_take;
    logic           render_take;
    logic           half_we;
    logic           full_we;
    logic           half_re;
    logic           full_re;
    logic [HAW-1:0] half_raddr;
    logic [FAW-1:0] full_raddr;
    logic [7:0]     half_rdata;
    logic [7:0]     full_rdata;
    logic [7:0]     rdata;
    logic [7:0]     code_sel;
    logic [11:0]    half_sum;
    logic [7:0]     full_row;
    logic [7:0]     row_value;
    logic           lead_half;
    logic           trail_half;

    assign load_take   = cmd.take && item.req_type == sjg_pkg::REQ_LOAD;
    assign render_take = cmd.take && item.req_type == sjg_pkg::REQ_RENDER;

    // Loads beyond a memory's depth are dropped
    assign half_we = load_take && item.load_table == sjg_pkg::TABLE_HALF &&
                     ({1'b0, item.load_address} < 17'(HALF_FONT_BYTES));
    assign full_we = load_take && item.load_table == sjg_pkg::TABLE_FULL &&
                     ({1'b0, item.load_address} < 17'(FULL_FONT_BYTES));

    // Read addresses
    assign code_sel   = cmd.rd_sel_trail ? trail_off_reg : lead_off_reg;
    assign half_sum   = sjg_pkg::HALF_GLYPH_BASE + 12'({code_sel, 3'b000}) +
                        12'(cmd.rd_row);
    assign half_raddr = HAW'(half_sum);
    assign full_raddr = FAW'({glyph_idx_reg, cmd.rd_row});
    assign half_re    = cmd.rd_en && mode_reg != sjg_pkg::MODE_FULL;
    assign full_re    = cmd.rd_en && mode_reg == sjg_pkg::MODE_FULL;
    assign rdata      = (mode_reg == sjg_pkg::MODE_FULL) ? full_rdata : half_rdata;

    sjg_ram #(
        .WIDTH (8),
        .DEPTH (HALF_FONT_BYTES)
    ) u_half_ram (
        .clk   (clk),
        .we    (half_we),
        .waddr (HAW'(item.load_address)),
        .wdata (item.load_data),
        .re    (half_re),
        .raddr (half_raddr),
        .rdata (half_rdata)
    );

    sjg_ram #(
        .WIDTH (8),
        .DEPTH (FULL_FONT_BYTES)
    ) u_full_ram (
        .clk   (clk),
        .we    (full_we),
        .waddr (FAW'(item.load_address)),
        .wdata (item.load_data),
        .re    (full_re),
        .raddr (full_raddr),
        .rdata (full_rdata)
    );

    assign lead_half  = sjg_pkg::is_half_width(item.lead_byte);
    assign trail_half = sjg_pkg::is_half_width(item.trail_byte);

    // Row out of the buffers: full-width takes bit 0 of each column
    always_comb
    begin
        for (int c = 0; c < 8; c++)
            full_row[3'(7 - c)] = buf_a_reg[c][0];
        unique case (mode_reg)
            sjg_pkg::MODE_FULL:      row_value = full_row;
            sjg_pkg::MODE_HALF_PAIR: row_value = swap_reg ?
                ((buf_a_reg[0] >> 4) | buf_b_reg[0]) :
                (buf_a_reg[0] | (buf_b_reg[0] >> 4));
            sjg_pkg::MODE_HALF_ONE:  row_value = buf_a_reg[0];
            default:                 row_value = buf_a_reg[0];
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg  <= '0;
            direction_reg <= '0;
            mode_reg      <= sjg_pkg::MODE_HALF_ONE;
            swap_reg      <= 1'b0;
            cap_valid_reg <= 1'b0;
            cap_trail_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sjg_pkg::CFG_ROTATION:  rotation_reg  <= cfg_data;
                    sjg_pkg::CFG_DIRECTION: direction_reg <= cfg_data;
                endcase
            end
            if (render_take)
            begin
                if (!lead_half)
                    mode_reg <= sjg_pkg::MODE_FULL;
                else if (trail_half)
                    mode_reg <= sjg_pkg::MODE_HALF_PAIR;
                else
                    mode_reg <= sjg_pkg::MODE_HALF_ONE;
                swap_reg <= (direction_reg == 2'(rotation_reg + 2'd1));
            end
            cap_valid_reg <= cmd.rd_en;
            cap_trail_reg <= cmd.rd_sel_trail;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (render_take)
        begin
            lead_off_reg  <= item.lead_byte - sjg_pkg::HALF_CODE_BIAS;
            trail_off_reg <= item.trail_byte - sjg_pkg::HALF_CODE_BIAS;
            glyph_idx_reg <= sjg_pkg::full_glyph_index(item.lead_byte,
                                                       item.trail_byte);
        end
        // fill: bytes shift in from the top, first read ends at entry 0
        if (cap_valid_reg)
        begin
            if (cap_trail_reg)
            begin
                for (int i = 0; i < 7; i++)
                    buf_b_reg[i] <= buf_b_reg[i + 1];
                buf_b_reg[7] <= rdata;
            end
            else
            begin
                for (int i = 0; i < 7; i++)
                    buf_a_reg[i] <= buf_a_reg[i + 1];
                buf_a_reg[7] <= rdata;
            end
        end
        else if (cmd.emit)
        begin
            if (mode_reg == sjg_pkg::MODE_FULL)
            begin
                for (int c = 0; c < 8; c++)
                    buf_a_reg[c] <= buf_a_reg[c] >> 1;
            end
            else
            begin
                for (int i = 0; i < 7; i++)
                begin
                    buf_a_reg[i] <= buf_a_reg[i + 1];
                    buf_b_reg[i] <= buf_b_reg[i + 1];
                end
            end
        end
        if (cmd.emit)
        begin
            row_index_reg  <= cmd.row_idx;
            row_bits_reg   <= row_value;
            chars_used_reg <= (mode_reg == sjg_pkg::MODE_HALF_ONE) ?
                              sjg_pkg::USED_ONE : sjg_pkg::USED_TWO;
            last_row_reg   <= (cmd.row_idx == sjg_pkg::LAST_ROW);
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.pair     = (mode_reg == sjg_pkg::MODE_HALF_PAIR);

    assign out_valid  = out_valid_reg;
    assign row_index  = row_index_reg;
    assign row_bits   = row_bits_reg;
    assign chars_used = chars_used_reg;
    assign last_row   = last_row_reg;

endmodule

[rtl/shift_jis_glyph_renderer.sv]
// Shift-JIS 8x8 glyph renderer. A load item (req_type 0) writes one font
// byte into the half-width or full-width font RAM in the cycle it is taken,
// gives no result, and the next item may follow at once. A render item
// (req_type 1) gives eight row items, rows 0..7, last_row set on row 7.
// Every glyph byte comes through the single read port of a font RAM, one
// byte per cycle, so a render keeps the input closed while its eight bytes
// (sixteen for two packed half-width characters) are read, over the read
// latency and while its eight rows go out; output row stalls add to that.
// The last row waits in the output register while the next item is
// accepted. Unmapped full-width codes show the space glyph. rotation_code
// and text_direction are written through cfg_we / cfg_index / cfg_data;
// the user must write them only while the block is idle, which the block
// does not enforce; font entries must be loaded before they are rendered.
module shift_jis_glyph_renderer #(
    parameter int HALF_FONT_BYTES = 2048,
    parameter int FULL_FONT_BYTES = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    sjg_cmd_if.sink    cmd,
    sjg_row_if.source  rows,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [1:0] cfg_data
);

    sjg_pkg::cmd_t     ctl_cmd;
    sjg_pkg::stat_t    dp_stat;
    sjg_pkg::in_item_t item;

    assign item.req_type     = cmd.req_type;
    assign item.load_table   = cmd.load_table;
    assign item.load_address = cmd.load_address;
    assign item.load_data    = cmd.load_data;
    assign item.lead_byte    = cmd.lead_byte;
    assign item.trail_byte   = cmd.trail_byte;

    sjg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cmd.valid),
        .in_req_type (cmd.req_type),
        .stat        (dp_stat),
        .in_ready    (cmd.ready),
        .cmd         (ctl_cmd)
    );

    sjg_dp #(
        .HALF_FONT_BYTES (HALF_FONT_BYTES),
        .FULL_FONT_BYTES (FULL_FONT_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctl_cmd),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_ready  (rows.ready),
        .stat       (dp_stat),
        .out_valid  (rows.valid),
        .row_index  (rows.row_index),
        .row_bits   (rows.row_bits),
        .chars_used (rows.chars_used),
        .last_row   (rows.last_row)
    );

`ifndef SYNTHESIS
    // a render keeps the input closed on the following cycle
    a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready && cmd.req_type == sjg_pkg::REQ_RENDER
        |=> !cmd.ready)
        else $error("input open right after a render item");

    // a load never blocks the next item
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready && cmd.req_type == sjg_pkg::REQ_LOAD
        |=> cmd.ready)
        else $error("input closed after a load item");

    // rows before the last one mean the render is still in progress
    a_rows_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid && !rows.last_row |-> !cmd.ready)
        else $error("input opened before the last row was produced");

    a_chars_used: assert property (@(posedge clk) disable iff (!rst_n)
        rows.valid |-> (rows.chars_used == sjg_pkg::USED_ONE ||
                        rows.chars_used == sjg_pkg::USED_TWO))
        else $error("bad chars_used on a row item");
`endif

endmodule

[tb/sv/tb_shift_jis_glyph_renderer.sv]
`timescale 1ns / 100ps

module tb_shift_jis_glyph_renderer;

    localparam int CLK_PERIOD    = 20;
    localparam int HALF_DEPTH    = 2048;
    localparam int FULL_DEPTH    = 65536;
    localparam int MAX_IDLE      = 18;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int TOTAL_ITEMS   = 270;
    localparam int MAX_PRINTED   = 100;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    // Shift-JIS mapping constants
    localparam int SJIS_FIRST    = 'h8140;
    localparam int KANJI_LEAD    = 'h88;
    localparam int KANJI_LOW     = 836;
    localparam int KANJI_HIGH    = 837;
    localparam int KANJI_ROW     = 67;
    localparam int KANJI_BLOCK2  = 12032;

    localparam logic [15:0] SPACE_GLYPH_ADDR = {sjg_pkg::SPACE_GLYPH_INDEX, 3'b000};

    typedef struct packed {
        logic [2:0] row_index;
        logic [7:0] row_bits;
        logic [1:0] chars_used;
        logic       last_row;
    } glyph_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [1:0] cfg_data;

    sjg_cmd_if cmd_ch ();
    sjg_row_if row_ch ();

    shift_jis_glyph_renderer #(
        .HALF_FONT_BYTES(HALF_DEPTH),
        .FULL_FONT_BYTES(FULL_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .rows     (row_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Mirror of the font memories and registers
    logic [7:0] half_font   [HALF_DEPTH];
    bit         half_loaded [HALF_DEPTH];
    logic [7:0] full_font   [FULL_DEPTH];
    bit         full_loaded [FULL_DEPTH];
    logic [1:0] rotation_q;
    logic [1:0] direction_q;

    glyph_row_t expected_rows [$];

    int error_count      = 0;
    int items_sent       = 0;
    int rows_hold_cycles = 0;
    bit cmd_eager        = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function automatic bit is_narrow(input logic [7:0] c);
        return (c >= 8'h20 && c <= 8'h7F) || (c >= 8'hA1 && c <= 8'hDF);
    endfunction

    // First byte of a half-width glyph
    function automatic int narrow_addr(input logic [7:0] c);
        int a;
        a = int'(sjg_pkg::HALF_GLYPH_BASE) + (int'(c) - int'(sjg_pkg::HALF_CODE_BIAS)) * 8;
        return a % HALF_DEPTH;
    endfunction

    // First byte of a full-width glyph; unmapped codes give the space glyph
    function automatic logic [15:0] wide_addr(input logic [7:0] hi, input logic [7:0] lo);
        int code;
        int off;
        int k;
        int adj;
        int bias;
        int v;
        code = int'({hi, lo});
        off  = code - SJIS_FIRST;
        k    = int'(hi) - KANJI_LEAD;
        if (!((hi >= 8'h81 && hi <= 8'h9F) || (hi >= 8'hE0 && hi <= 8'hEF)))
            return SPACE_GLYPH_ADDR;
        if (code >= 'h8140 && code <= 'h88FC)
        begin
            // non-kanji blocks, each with its own offset
            if (code <= 'h817E) adj = 16;
            else if (code >= 'h8180 && code <= 'h81FC) adj = 15;
            else if (code >= 'h824F && code <= 'h8279) adj = -52;
            else if (code >= 'h8281 && code <= 'h82F1) adj = -53;
            else if (code >= 'h8340 && code <= 'h837E) adj = -120;
            else if (code >= 'h8380 && code <= 'h83D6) adj = -121;
            else if (code >= 'h8440 && code <= 'h847E) adj = -188;
            else if (code >= 'h8480 && code <= 'h84BE) adj = -189;
            else if (code >= 'h8740 && code <= 'h877E) adj = -768;
            else if (code >= 'h8780 && code <= 'h879C) adj = -769;
            else if (code >= 'h889F) adj = -837;
            else return SPACE_GLYPH_ADDR;
            v = off + adj;
        end
        else if ((code >= 'h8940 && code <= 'h9FFC) || (code >= 'hE040 && code <= 'hEAA4))
        begin
            // kanji; trail 0x7F is a hole
            if (lo == 8'h7F)
                return SPACE_GLYPH_ADDR;
            bias = (lo <= 8'h7E) ? KANJI_LOW : KANJI_HIGH;
            v = off - (bias + k) - KANJI_ROW * k;
            if (code >= 'hE040)
                v = v - KANJI_BLOCK2;
        end
        else
            return SPACE_GLYPH_ADDR;
        return 16'(v * 8);
    endfunction

    // Expected eight rows of a render
    task automatic predict_glyph_rows(input logic [7:0] lead, input logic [7:0] trail);
        logic [7:0]  glyph  [8];
        logic [7:0]  second [8];
        logic [7:0]  cols   [8];
        logic [15:0] fbase;
        logic [1:0]  used;
        bit          swap;
        int          base;
        glyph_row_t  row;
        if (is_narrow(lead))
        begin
            base = narrow_addr(lead);
            for (int i = 0; i < 8; i++)
                glyph[i] = half_font[(base + i) % HALF_DEPTH];
            used = sjg_pkg::USED_ONE;
            if (is_narrow(trail))
            begin
                base = narrow_addr(trail);
                for (int i = 0; i < 8; i++)
                    second[i] = half_font[(base + i) % HALF_DEPTH];
                swap = (direction_q == 2'(rotation_q + 2'd1));
                for (int i = 0; i < 8; i++)
                    glyph[i] = swap ? ((glyph[i] >> 4) | second[i])
                                    : (glyph[i] | (second[i] >> 4));
                used = sjg_pkg::USED_TWO;
            end
        end
        else
        begin
            // stored as columns, transposed into rows
            fbase = wide_addr(lead, trail);
            for (int c = 0; c < 8; c++)
                cols[c] = full_font[16'(fbase + c)];
            for (int r = 0; r < 8; r++)
                for (int c = 0; c < 8; c++)
                    glyph[r][7 - c] = cols[c][r];
            used = sjg_pkg::USED_TWO;
        end
        for (int r = 0; r < sjg_pkg::GLYPH_ROWS; r++)
        begin
            row.row_index  = 3'(r);
            row.row_bits   = glyph[r];
            row.chars_used = used;
            row.last_row   = (3'(r) == sjg_pkg::LAST_ROW);
            expected_rows.push_back(row);
        end
    endtask

    // Update the mirror for an accepted item
    task automatic apply_item(input sjg_pkg::in_item_t it);
        items_sent++;
        if (it.req_type == sjg_pkg::REQ_LOAD)
        begin
            if (it.load_table == sjg_pkg::TABLE_HALF)
            begin
                if (it.load_address < HALF_DEPTH)
                begin
                    half_font[it.load_address]   = it.load_data;
                    half_loaded[it.load_address] = 1'b1;
                end
            end
            else
            begin
                full_font[it.load_address]   = it.load_data;
                full_loaded[it.load_address] = 1'b1;
            end
        end
        else
            predict_glyph_rows(it.lead_byte, it.trail_byte);
    endtask

    // Offer one item; valid stays high after the handshake
    task automatic send_item(input sjg_pkg::in_item_t it);
        int gap;
        gap = cmd_eager ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.req_type     <= it.req_type;
        cmd_ch.load_table   <= it.load_table;
        cmd_ch.load_address <= it.load_address;
        cmd_ch.load_data    <= it.load_data;
        cmd_ch.lead_byte    <= it.lead_byte;
        cmd_ch.trail_byte   <= it.trail_byte;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        apply_item(it);
    endtask

    task automatic load_byte(input logic sel, input logic [15:0] addr, input logic [7:0] data);
        sjg_pkg::in_item_t it;
        it.req_type     = sjg_pkg::REQ_LOAD;
        it.load_table   = sel;
        it.load_address = addr;
        it.load_data    = data;
        it.lead_byte    = 8'($urandom);
        it.trail_byte   = 8'($urandom);
        send_item(it);
    endtask

    task automatic fill_narrow(input logic [7:0] c);
        int base;
        base = narrow_addr(c);
        for (int i = 0; i < 8; i++)
            if (!half_loaded[(base + i) % HALF_DEPTH])
                load_byte(sjg_pkg::TABLE_HALF, 16'((base + i) % HALF_DEPTH), 8'($urandom));
    endtask

    // Load whatever glyph bytes are still missing, then render
    task automatic render_char(input logic [7:0] lead, input logic [7:0] trail);
        logic [15:0]       fbase;
        sjg_pkg::in_item_t it;
        if (is_narrow(lead))
        begin
            fill_narrow(lead);
            if (is_narrow(trail))
                fill_narrow(trail);
        end
        else
        begin
            fbase = wide_addr(lead, trail);
            for (int i = 0; i < 8; i++)
                if (!full_loaded[16'(fbase + i)])
                    load_byte(sjg_pkg::TABLE_FULL, 16'(fbase + i), 8'($urandom));
        end
        it.req_type     = sjg_pkg::REQ_RENDER;
        it.load_table   = 1'($urandom);
        it.load_address = 16'($urandom);
        it.load_data    = 8'($urandom);
        it.lead_byte    = lead;
        it.trail_byte   = trail;
        send_item(it);
    endtask

    // Stop offering items and let every expected row come out
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [0:0] idx, input logic [1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == sjg_pkg::CFG_ROTATION)
            rotation_q = val;
        else
            direction_q = val;
    endtask

    task automatic set_mode(input logic [1:0] rot, input logic [1:0] dir);
        write_config(sjg_pkg::CFG_ROTATION, rot);
        write_config(sjg_pkg::CFG_DIRECTION, dir);
    endtask

    function automatic logic [7:0] rand_narrow();
        if ($urandom_range(0, 1))
            return 8'($urandom_range('h20, 'h7F));
        return 8'($urandom_range('hA1, 'hDF));
    endfunction

    // Half-width codes whose glyphs the first test already loads
    function automatic logic [7:0] rand_known_narrow();
        case ($urandom_range(0, 3))
            0: return 8'h20;
            1: return 8'h7F;
            2: return 8'hA1;
            default: return 8'hDF;
        endcase
    endfunction

    // Any byte that is not a half-width code
    function automatic logic [7:0] rand_other();
        case ($urandom_range(0, 2))
            0: return 8'($urandom_range('h00, 'h1F));
            1: return 8'($urandom_range('h80, 'hA0));
            default: return 8'($urandom_range('hE0, 'hFF));
        endcase
    endfunction

    function automatic logic [7:0] rand_wide_lead();
        case ($urandom_range(0, 5))
            0, 1, 2: return 8'($urandom_range('h81, 'h9F));
            3, 4: return 8'($urandom_range('hE0, 'hEA));
            default: return 8'($urandom_range('hEB, 'hEF));
        endcase
    endfunction

    // Half-width singles, pairs and dropped loads
    task automatic test_halfwidth_glyphs();
        set_mode(2'd0, 2'd0);
        render_char(8'h20, 8'h00);
        render_char(8'hDF, 8'hFF);
        render_char(8'h7F, 8'h80);
        render_char(8'hA1, 8'hA0);
        render_char(8'h20, 8'hDF);
        render_char(8'hDF, 8'h7F);
        // loads past the half-width depth must not alias onto glyph 0x20
        load_byte(sjg_pkg::TABLE_HALF, 16'h0910, ~half_font[narrow_addr(8'h20)]);
        load_byte(sjg_pkg::TABLE_HALF, 16'hF910, ~half_font[narrow_addr(8'h20)]);
        render_char(8'h20, 8'h1F);
    endtask

    // Full-width mapping edges and unmapped codes
    task automatic test_fullwidth_mapping();
        render_char(8'h81, 8'h40);
        render_char(8'hEA, 8'hA4);
        render_char(8'h88, 8'h9F);
        render_char(8'hE0, 8'h40);
        render_char(8'h00, 8'h00);
        render_char(8'hFF, 8'hFF);
        render_char(8'h80, 8'h40);
        render_char(8'hA0, 8'hFC);
        render_char(8'h82, 8'h00);
        render_char(8'h89, 8'h7F);
        render_char(8'hEA, 8'hA5);
        render_char(8'hEF, 8'hFC);
        render_char(8'h81, 8'h3F);
    endtask

    // Nibble order of half-width pairs under eight rotation and direction settings
    task automatic test_nibble_order();
        logic [1:0] rot_list [8] = '{2'd0, 2'd0, 2'd3, 2'd3, 2'd1, 2'd2, 2'd2, 2'd1};
        logic [1:0] dir_list [8] = '{2'd0, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd1};
        for (int s = 0; s < 8; s++)
        begin
            wait_drained();
            set_mode(rot_list[s], dir_list[s]);
            render_char(rand_known_narrow(), rand_known_narrow());
            render_char(rand_known_narrow(), rand_known_narrow());
            render_char(rand_known_narrow(), rand_other());
        end
    endtask

    // Long output stall with the sender pushing, then a full drain
    task automatic test_backpressure();
        wait_drained();
        rows_hold_cycles = HOLD_CYCLES;
        cmd_eager = 1'b1;
        for (int n = 0; n < 4; n++)
            render_char(rand_narrow(), rand_narrow());
        render_char(8'h81, 8'h40);
        render_char(rand_wide_lead(), 8'($urandom_range('h40, 'hFC)));
        cmd_eager = 1'b0;
        wait_drained();
    endtask

    // Mostly load-then-render sequences, some noise, up to the item budget
    task automatic test_random_traffic();
        int count;
        int pick;
        count = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (count % 8 == 0)
                cmd_eager = ($urandom_range(0, 3) == 0);
            if (count > 0 && count % 10 == 0)
            begin
                wait_drained();
                set_mode(2'($urandom), 2'($urandom));
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
                render_char(rand_narrow(), rand_narrow());
            else if (pick < 50)
                render_char(rand_narrow(), rand_other());
            else if (pick < 82)
                render_char(rand_wide_lead(), 8'($urandom_range('h40, 'hFC)));
            else if (pick < 90)
                render_char(8'($urandom), 8'($urandom));
            else
                load_byte(1'($urandom), 16'($urandom), 8'($urandom));
            count++;
        end
        cmd_eager = 1'b0;
    endtask

    // Row receiver and checker
    initial
    begin : row_sink
        int         stall;
        int         rows_seen;
        bit         eager;
        glyph_row_t want;
        row_ch.ready <= 1'b0;
        rows_seen = 0;
        eager     = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rows_hold_cycles > 0)
            begin
                row_ch.ready <= 1'b0;
                repeat (rows_hold_cycles) @(posedge clk);
                rows_hold_cycles = 0;
            end
            if (rows_seen % 16 == 0)
                eager = ($urandom_range(0, 3) == 0);
            stall = eager ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                row_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            row_ch.ready <= 1'b1;
            @(posedge clk);
            while (!row_ch.valid) @(posedge clk);
            rows_seen++;
            if (expected_rows.size() == 0)
                report_mismatch($sformatf("row item with nothing expected: row %0d bits %02h",
                                          row_ch.row_index, row_ch.row_bits));
            else
            begin
                want = expected_rows.pop_front();
                if (row_ch.row_index !== want.row_index)
                    report_mismatch($sformatf("row_index got %0d want %0d",
                                              row_ch.row_index, want.row_index));
                if (row_ch.row_bits !== want.row_bits)
                    report_mismatch($sformatf("row %0d row_bits got %02h want %02h",
                                              want.row_index, row_ch.row_bits, want.row_bits));
                if (row_ch.chars_used !== want.chars_used)
                    report_mismatch($sformatf("row %0d chars_used got %0d want %0d",
                                              want.row_index, row_ch.chars_used,
                                              want.chars_used));
                if (row_ch.last_row !== want.last_row)
                    report_mismatch($sformatf("row %0d last_row got %0b want %0b",
                                              want.row_index, row_ch.last_row, want.last_row));
            end
        end
    end

    // Test sequence
    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= sjg_pkg::CFG_ROTATION;
        cfg_data            <= 2'd0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.req_type     <= sjg_pkg::REQ_LOAD;
        cmd_ch.load_table   <= sjg_pkg::TABLE_HALF;
        cmd_ch.load_address <= 16'd0;
        cmd_ch.load_data    <= 8'd0;
        cmd_ch.lead_byte    <= 8'd0;
        cmd_ch.trail_byte   <= 8'd0;
        rotation_q  = 2'd0;
        direction_q = 2'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_halfwidth_glyphs();
        test_fullwidth_mapping();
        test_nibble_order();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (expected_rows.size() != 0)
            report_mismatch($sformatf("%0d rows never arrived", expected_rows.size()));
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[shift_jis_glyph_renderer.f]
rtl/sjg_pkg.sv
rtl/sjg_cmd_if.sv
rtl/sjg_row_if.sv
rtl/sjg_ram.sv
rtl/sjg_ctrl.sv
rtl/sjg_dp.sv
rtl/shift_jis_glyph_renderer.sv
tb/sv/tb_shift_jis_glyph_renderer.sv
